// ===== hdl/archive_directory_lookup_macros.svh =====
// ----------------------------------------------------------------------------
// archive directory lookup assertion macros
// shared property forms for the lookup block checks
// ----------------------------------------------------------------------------
`ifndef ARCHIVE_DIRECTORY_LOOKUP_MACROS_SVH
`define ARCHIVE_DIRECTORY_LOOKUP_MACROS_SVH

// same-cycle implication
`define ADL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adl check failed");

// next-cycle implication
`define ADL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adl check failed");

`endif

// ===== hdl/adl_pkg.sv =====
// ----------------------------------------------------------------------------
// adl_pkg
// types and constants of the archive directory lookup block
// ----------------------------------------------------------------------------
package adl_pkg;

  localparam int NAME_CHARS = 12;
  localparam int NAME_BITS  = 8 * NAME_CHARS;
  localparam int HASH_STEPS = 3;
  localparam int TALK_STEPS = 6;

  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [7:0]  LOWER_A     = 8'h61;
  localparam logic [7:0]  LOWER_Z     = 8'h7a;
  localparam logic [7:0]  CASE_GAP    = 8'h20;
  localparam logic [31:0] ENTRY_BIAS  = 32'd6;
  localparam logic [31:0] ENTRY_BYTES = 32'd12;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic REG_TALK_MODE   = 1'b0;
  localparam logic REG_ENTRY_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEY,
    S_PROBE,
    S_LOAD,
    S_START,
    S_END,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic talk_mode;
  } key_req_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] offset;
    logic [31:0] length;
  } dir_row_t;

  localparam int DIR_ROW_W = $bits(dir_row_t);

endpackage

// ===== hdl/archive_directory_lookup.sv =====
// ----------------------------------------------------------------------------
// archive_directory_lookup
// directory table load with order check, and name lookup by binary search
// ----------------------------------------------------------------------------
// Request words (req_valid/req_stall) carry either a directory entry load
// (action 0) or a name lookup (action 1); one response word
// (rsp_valid/rsp_stall) follows every request. The block takes one request
// at a time and holds req_stall high until the request has been worked.
// A load reads the directory row for the preceding id, then writes the
// entry and checks the order. A lookup builds the id in the id unit, makes
// at most log2(MAX_ENTRIES)+1 search probes, one directory read each, and on
// a hit works out the offsets in S_START and S_END before the response.
// The response register frees the request side: a new request is taken
// while an earlier response still waits, and the block stalls in its final
// state only if the receiver holds rsp_stall.
// Reset clears talk_mode, entry_count and all control state; the directory
// contents are undefined until loaded. cfg_we writes a register at once and
// must be used only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "archive_directory_lookup_macros.svh"

module archive_directory_lookup #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        action,
  input  logic [9:0]  load_index,
  input  logic signed [31:0] load_hash,
  input  logic [31:0] load_offset,
  input  logic [31:0] load_length,
  input  logic [31:0] name_chars_0_3,
  input  logic [31:0] name_chars_4_7,
  input  logic [31:0] name_chars_8_11,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        found,
  output logic [10:0] match_index,
  output logic [31:0] data_start,
  output logic [31:0] data_end,
  output logic        order_error
);
  import adl_pkg::*;

  localparam int A_W = $clog2(MAX_ENTRIES);
  localparam int C_W = $clog2(MAX_ENTRIES + 1);

  state_t         state, state_next;
  logic           talk_mode;
  logic [10:0]    entry_count;
  key_req_t       key_req;
  logic           key_done;
  logic [31:0]    key_value;
  logic [31:0]    key;
  logic [C_W-1:0] lo, hi, lo_step, hi_step, hi_init;
  logic [A_W-1:0] mid, rd_addr;
  logic [A_W-1:0] ld_idx;
  logic           ld_first;
  dir_row_t       ld_row, row;
  logic [DIR_ROW_W-1:0] row_bits;
  logic           req_accept, in_range, key_gt, key_lt, rsp_load;
  logic           w_found, w_err;
  logic [10:0]    w_index;
  logic [31:0]    w_start, w_end, hit_offset, hit_length;

  function automatic logic [C_W-1:0] mid_point(input logic [C_W-1:0] a,
                                               input logic [C_W-1:0] b);
    mid_point = a + ((b - a) >> 1);
  endfunction

  adl_key_unit u_key (
    .clk    (clk),
    .rst    (rst),
    .req    (key_req),
    .word_0 (name_chars_0_3),
    .word_1 (name_chars_4_7),
    .word_2 (name_chars_8_11),
    .done   (key_done),
    .key    (key_value)
  );

  adl_dir_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (A_W),
    .W     (DIR_ROW_W)
  ) u_dir (
    .clk   (clk),
    .we    (state == S_LOAD),
    .waddr (ld_idx),
    .wdata (ld_row),
    .raddr (rd_addr),
    .rdata (row_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      talk_mode   <= 1'b0;
      entry_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TALK_MODE:   talk_mode   <= cfg_data[0];
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    row        = dir_row_t'(row_bits);
    req_stall  = (state != S_IDLE);
    req_accept = req_valid && !req_stall;
    in_range   = 32'(load_index) < 32'(MAX_ENTRIES);
    hi_init    = (32'(entry_count) > 32'(MAX_ENTRIES)) ? C_W'(MAX_ENTRIES)
                                                       : C_W'(entry_count);
    key_gt     = $signed(key) > $signed(row.id);
    key_lt     = $signed(key) < $signed(row.id);
    lo_step    = key_gt ? (C_W'(mid) + C_W'(1)) : lo;
    hi_step    = key_lt ? C_W'(mid) : hi;
    rsp_load   = (state == S_DONE) && (!rsp_valid || !rsp_stall);
    key_req.start     = req_accept && (action == ACT_LOOKUP);
    key_req.talk_mode = talk_mode;
    rd_addr    = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_accept) begin
          if (action == ACT_LOOKUP) begin
            state_next = S_KEY;
          end else if (in_range) begin
            rd_addr    = A_W'(32'(load_index) - 32'd1);
            state_next = S_LOAD;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_KEY: begin
        if (key_done) begin
          rd_addr    = A_W'(hi_init >> 1);
          state_next = (hi_init == '0) ? S_DONE : S_PROBE;
        end
      end
      S_PROBE: begin
        rd_addr = A_W'(mid_point(lo_step, hi_step));
        if (!key_gt && !key_lt) begin
          state_next = S_START;
        end else if (lo_step >= hi_step) begin
          state_next = S_DONE;
        end
      end
      S_LOAD:  state_next = S_DONE;
      S_START: state_next = S_END;
      S_END:   state_next = S_DONE;
      S_DONE: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_accept) begin
          ld_idx   <= A_W'(load_index);
          ld_first <= (load_index == '0);
          ld_row   <= '{id: load_hash, offset: load_offset, length: load_length};
          w_found  <= 1'b0;
          w_index  <= '0;
          w_start  <= '0;
          w_end    <= '0;
          w_err    <= 1'b0;
        end
      end
      S_KEY: begin
        if (key_done) begin
          key     <= key_value;
          lo      <= '0;
          hi      <= hi_init;
          mid     <= A_W'(hi_init >> 1);
          w_index <= entry_count;
        end
      end
      S_PROBE: begin
        lo  <= lo_step;
        hi  <= hi_step;
        mid <= A_W'(mid_point(lo_step, hi_step));
        if (!key_gt && !key_lt) begin
          w_found    <= 1'b1;
          w_index    <= 11'(mid);
          hit_offset <= row.offset;
          hit_length <= row.length;
        end
      end
      S_LOAD: begin
        w_err <= !ld_first && !($signed(ld_row.id) > $signed(row.id));
      end
      S_START: begin
        w_start <= hit_offset + ENTRY_BIAS + 32'(entry_count) * ENTRY_BYTES;
      end
      S_END: begin
        w_end <= hit_length + w_start;
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      found       <= w_found;
      match_index <= w_index;
      data_start  <= w_start;
      data_end    <= w_end;
      order_error <= w_err;
    end
  end

  `ADL_ASSERT_IMP(a_probe_window, clk, rst, state == S_PROBE, lo < hi)
  `ADL_ASSERT_IMP(a_probe_mid, clk, rst, state == S_PROBE, (C_W'(mid) >= lo) && (C_W'(mid) < hi))
  `ADL_ASSERT_IMP(a_key_done_state, clk, rst, key_done, state == S_KEY)
  `ADL_ASSERT_NXT(a_hit_path, clk, rst, state == S_START, (state == S_END) && w_found)
  `ADL_ASSERT_IMP(a_miss_zero, clk, rst, rsp_valid && !found, (data_start == '0) && (data_end == '0))

endmodule

// ===== hdl/adl_dir_ram.sv =====
// ----------------------------------------------------------------------------
// adl_dir_ram
// directory store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module adl_dir_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/adl_key_unit.sv =====
// ----------------------------------------------------------------------------
// adl_key_unit
// name id unit: uppercases the name, then builds the id one step a cycle
// with an adder shared by both modes (rotate-add hash or decimal talk id)
// ----------------------------------------------------------------------------
module adl_key_unit (
  input  logic             clk,
  input  logic             rst,
  input  adl_pkg::key_req_t req,
  input  logic [31:0]      word_0,
  input  logic [31:0]      word_1,
  input  logic [31:0]      word_2,
  output logic             done,
  output logic [31:0]      key
);
  import adl_pkg::*;

  logic [NAME_BITS-1:0] prepared;
  logic [NAME_BITS-1:0] chars;
  logic [31:0]          acc;
  logic [31:0]          acc_next;
  logic [31:0]          pre;
  logic [31:0]          addend;
  logic [31:0]          digit;
  logic [2:0]           step;
  logic                 busy;
  logic                 talk;
  logic                 last;
  logic                 stop_early;

  // name ends at the first zero byte, a..z uppercased
  always_comb begin
    logic                 ended;
    logic [7:0]           c;
    logic [NAME_BITS-1:0] raw;
    ended = 1'b0;
    raw   = {word_2, word_1, word_0};
    prepared = '0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      c = raw[8*i +: 8];
      if (c == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        c = 8'h00;
      end
      if (c >= LOWER_A && c <= LOWER_Z) begin
        c = c - CASE_GAP;
      end
      prepared[8*i +: 8] = c;
    end
  end

  // shared step
  always_comb begin
    digit      = 32'(chars[7:0]) - 32'(ASCII_ZERO);
    pre        = talk ? ((acc << 3) + (acc << 1)) : {acc[30:0], acc[31]};
    addend     = talk ? digit : chars[31:0];
    acc_next   = pre + addend;
    last       = talk ? (step == 3'(TALK_STEPS - 1)) : (step == 3'(HASH_STEPS - 1));
    stop_early = !talk && (chars[7:0] == 8'h00);
    key        = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (stop_early || last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      talk  <= req.talk_mode;
      chars <= prepared;
      acc   <= '0;
    end else if (busy && !stop_early) begin
      acc <= acc_next;
      if (!talk) begin
        chars <= chars >> 32;
      end else if (step == 3'd1) begin
        chars <= chars >> 16;
      end else begin
        chars <= chars >> 8;
      end
    end
  end

endmodule

// ===== tb/sv/archive_directory_lookup_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// archive_directory_lookup_tb
// Self-checking bench for the directory load and name lookup block. Directory
// entries are loaded as sorted tables of name ids, sometimes with stray or
// repeated ids to raise order errors. Lookups then use names from the table
// with case changes and junk after the terminator, fresh names and raw
// noise. Both id modes and entry counts from 0 up to 2047 are covered, the
// last with the full 1024-entry table. A model inside the bench predicts
// every response word, and a checker compares it field by field in order.
// Both sides idle at random, and one long response hold-off fills the block.
// ----------------------------------------------------------------------------
module archive_directory_lookup_tb;
  import adl_pkg::*;

  localparam int DIR_DEPTH    = 1024;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int LONG_HOLD    = 300;
  localparam int REPORT_MAX   = 10;
  localparam int TAIL_CYCLES  = 40;

  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5a;
  localparam logic [7:0] DOT        = 8'h2e;
  localparam logic [7:0] UNDERSCORE = 8'h5f;

  typedef struct {
    bit        act;
    bit [9:0]  idx;
    bit [31:0] hash;
    bit [31:0] offset;
    bit [31:0] length;
    bit [95:0] name;
  } dir_word_t;

  typedef struct {
    bit        found;
    bit [10:0] match_index;
    bit [31:0] data_start;
    bit [31:0] data_end;
    bit        order_error;
  } dir_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [10:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic        action;
  logic [9:0]  load_index;
  logic signed [31:0] load_hash;
  logic [31:0] load_offset;
  logic [31:0] load_length;
  logic [31:0] name_chars_0_3;
  logic [31:0] name_chars_4_7;
  logic [31:0] name_chars_8_11;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        found;
  logic [10:0] match_index;
  logic [31:0] data_start;
  logic [31:0] data_end;
  logic        order_error;

  archive_directory_lookup dut (.*);

  // directory copy and register copy
  bit [31:0] dir_id     [DIR_DEPTH];
  bit [31:0] dir_offset [DIR_DEPTH];
  bit [31:0] dir_length [DIR_DEPTH];
  bit        talk_sel;
  bit [10:0] entry_total;

  // sorted table under construction
  bit [31:0] pick_key  [DIR_DEPTH];
  bit [95:0] pick_name [DIR_DEPTH];
  int        pick_count;

  dir_reply_t awaited_replies [$];
  dir_reply_t front_reply;

  bit sender_steady;
  bit receiver_steady;
  bit hold_off_req;
  int hold_offs;
  int mismatches;
  int cycle_count;
  int loads_sent;
  int lookups_sent;
  int hits_due;
  int order_errors_due;
  int widest_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // name handling

  function automatic bit [95:0] fold_name(bit [95:0] raw);
    bit [95:0] ch;
    bit [7:0]  c;
    bit        ended;
    ch = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      c = raw[8*i +: 8];
      if (c == 8'h00) ended = 1'b1;
      if (ended) c = 8'h00;
      if (c >= LOWER_A && c <= LOWER_Z) c = c - CASE_GAP;
      ch[8*i +: 8] = c;
    end
    return ch;
  endfunction

  function automatic bit [31:0] name_hash_of(bit [95:0] ch);
    bit [31:0] id;
    bit        live;
    id = '0;
    live = 1'b1;
    for (int w = 0; w < 3; w++) begin
      if (ch[32*w +: 8] == 8'h00) live = 1'b0;
      if (live) id = {id[30:0], id[31]} + ch[32*w +: 32];
    end
    return id;
  endfunction

  function automatic bit [31:0] talk_id_of(bit [95:0] ch);
    bit [31:0] d [7];
    bit [31:0] actor;
    bit [31:0] speech;
    for (int k = 0; k < 7; k++) d[k] = {24'h0, ch[8*k +: 8]} - {24'h0, ASCII_ZERO};
    actor  = 32'd10 * d[0] + d[1];
    speech = 32'd1000 * d[3] + 32'd100 * d[4] + 32'd10 * d[5] + d[6];
    return 32'd10000 * actor + speech;
  endfunction

  function automatic bit [31:0] key_for(bit [95:0] raw, bit talk);
    bit [95:0] ch;
    ch = fold_name(raw);
    return talk ? talk_id_of(ch) : name_hash_of(ch);
  endfunction

  function automatic dir_reply_t directory_reply(dir_word_t w);
    dir_reply_t r;
    bit [31:0]  key;
    bit         hit;
    int         lo, hi, mid, pos;
    r = '{default: 0};
    if (w.act == ACT_LOAD) begin
      dir_id[w.idx]     = w.hash;
      dir_offset[w.idx] = w.offset;
      dir_length[w.idx] = w.length;
      if (w.idx != 0 && !($signed(w.hash) > $signed(dir_id[w.idx - 1])))
        r.order_error = 1'b1;
      loads_sent++;
      if (r.order_error) order_errors_due++;
      return r;
    end
    key = key_for(w.name, talk_sel);
    lo  = 0;
    hi  = (entry_total > DIR_DEPTH) ? DIR_DEPTH : int'(entry_total);
    hit = 1'b0;
    pos = 0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if ($signed(key) > $signed(dir_id[mid])) lo = mid + 1;
      else if ($signed(dir_id[mid]) > $signed(key)) hi = mid;
      else begin
        hit = 1'b1;
        pos = mid;
      end
    end
    lookups_sent++;
    if (!hit) begin
      r.match_index = entry_total;
      return r;
    end
    hits_due++;
    r.found       = 1'b1;
    r.match_index = 11'(pos);
    r.data_start  = dir_offset[pos] + ENTRY_BIAS + ENTRY_BYTES * {21'h0, entry_total};
    r.data_end    = dir_length[pos] + r.data_start;
    return r;
  endfunction

  // random names

  function automatic bit [95:0] pack_text(string s);
    bit [95:0] nm;
    nm = '0;
    for (int i = 0; i < s.len() && i < NAME_CHARS; i++) nm[8*i +: 8] = s[i];
    return nm;
  endfunction

  function automatic bit [95:0] random_name(bit talk);
    bit [95:0] nm;
    int        len, r;
    nm = '0;
    if (talk) len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, NAME_CHARS) : 7;
    else len = $urandom_range(1, NAME_CHARS);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (talk && r < 88)
        nm[8*i +: 8] = (i == 2) ? UNDERSCORE : ASCII_ZERO + 8'($urandom_range(0, 9));
      else if (r < 40) nm[8*i +: 8] = UPPER_A + 8'($urandom_range(0, 25));
      else if (r < 60) nm[8*i +: 8] = LOWER_A + 8'($urandom_range(0, 25));
      else if (r < 75) nm[8*i +: 8] = ASCII_ZERO + 8'($urandom_range(0, 9));
      else if (r < 82) nm[8*i +: 8] = DOT;
      else if (r < 92) nm[8*i +: 8] = 8'($urandom_range(8'h80, 8'hff));
      else nm[8*i +: 8] = 8'($urandom_range(1, 8'h7f));
    end
    return nm;
  endfunction

  // same name after folding: random case flips, junk after the terminator
  function automatic bit [95:0] vary_name(bit [95:0] nm);
    bit [7:0] c;
    bit       ended;
    ended = 1'b0;
    for (int i = 0; i < NAME_CHARS; i++) begin
      c = nm[8*i +: 8];
      if (ended) c = 8'($urandom);
      else if (c == 8'h00) ended = 1'b1;
      else if (c >= UPPER_A && c <= UPPER_Z && $urandom_range(0, 1) == 1) c = c + CASE_GAP;
      nm[8*i +: 8] = c;
    end
    return nm;
  endfunction

  function automatic void insert_pick(bit [95:0] nm, bit talk);
    bit [31:0] key;
    int        p;
    key = key_for(nm, talk);
    p = 0;
    while (p < pick_count && $signed(pick_key[p]) < $signed(key)) p++;
    if (p < pick_count && pick_key[p] == key) return;
    for (int j = pick_count; j > p; j--) begin
      pick_key[j]  = pick_key[j - 1];
      pick_name[j] = pick_name[j - 1];
    end
    pick_key[p]  = key;
    pick_name[p] = nm;
    pick_count++;
  endfunction

  function automatic void build_table(bit talk, int n);
    pick_count = 0;
    while (pick_count < n) insert_pick(random_name(talk), talk);
  endfunction

  function automatic int pick_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // request side

  task automatic send_word(input dir_word_t w);
    int gap;
    @(negedge clk);
    req_valid       <= 1'b1;
    action          <= w.act;
    load_index      <= w.idx;
    load_hash       <= w.hash;
    load_offset     <= w.offset;
    load_length     <= w.length;
    name_chars_0_3  <= w.name[31:0];
    name_chars_4_7  <= w.name[63:32];
    name_chars_8_11 <= w.name[95:64];
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited_replies.push_back(directory_reply(w));
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_load(input int idx, input bit [31:0] hash, input bit [31:0] off,
                           input bit [31:0] len);
    dir_word_t w;
    w.act    = ACT_LOAD;
    w.idx    = 10'(idx);
    w.hash   = hash;
    w.offset = off;
    w.length = len;
    w.name   = {$urandom, $urandom, $urandom};
    send_word(w);
  endtask

  task automatic send_lookup(input bit [95:0] nm);
    dir_word_t w;
    w.act    = ACT_LOOKUP;
    w.idx    = 10'($urandom);
    w.hash   = $urandom;
    w.offset = $urandom;
    w.length = $urandom;
    w.name   = nm;
    send_word(w);
  endtask

  // loads the sorted table from index 0, at times after a stray or repeated id
  task automatic load_picks(input bit noisy);
    for (int i = 0; i < pick_count; i++) begin
      if (noisy && $urandom_range(0, 14) == 0) begin
        send_load(i, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 3) == 0) continue;
      end else if (noisy && i > 0 && $urandom_range(0, 19) == 0) begin
        send_load(i, pick_key[i - 1], $urandom, $urandom);
      end
      send_load(i, pick_key[i], $urandom, $urandom);
    end
  endtask

  task automatic send_lookup_mix(input int m);
    int r, j;
    for (int k = 0; k < m; k++) begin
      r = $urandom_range(0, 99);
      if (r < 65 && pick_count > 0) begin
        send_lookup(vary_name(pick_name[$urandom_range(0, pick_count - 1)]));
      end else if (r < 80) begin
        send_lookup(random_name(talk_sel));
      end else if (r < 90 || pick_count == 0) begin
        send_lookup({$urandom, $urandom, $urandom});
      end else begin
        j = $urandom_range(0, pick_count - 1);
        send_load(j, pick_key[j], $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input bit [10:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TALK_MODE) talk_sel = val[0];
    else begin
      entry_total = val;
      if (int'(val) > widest_count) widest_count = int'(val);
    end
  endtask

  task automatic configure(input bit talk, input int count);
    wait_idle();
    write_reg(REG_TALK_MODE, {10'h0, talk});
    write_reg(REG_ENTRY_COUNT, 11'(count));
  endtask

  // response side

  initial begin
    int left, held, r;
    rsp_stall = 1'b0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        rsp_stall <= 1'b1;
        for (held = 1; held < LONG_HOLD; held++) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else if (left > 0) begin
        rsp_stall <= 1'b1;
        left--;
      end else begin
        r = $urandom_range(0, 99);
        if (receiver_steady || r < 70) rsp_stall <= 1'b0;
        else if (r < 94) begin
          rsp_stall <= 1'b1;
          left = $urandom_range(0, 2);
        end else begin
          rsp_stall <= 1'b1;
          left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: response word with none awaited", $time);
      end else begin
        front_reply = awaited_replies.pop_front();
        if (found !== front_reply.found || match_index !== front_reply.match_index ||
            data_start !== front_reply.data_start || data_end !== front_reply.data_end ||
            order_error !== front_reply.order_error) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: mismatch exp found=%0b idx=%0d start=%h end=%h err=%0b",
                     $time, front_reply.found, front_reply.match_index,
                     front_reply.data_start, front_reply.data_end, front_reply.order_error,
                     "\n          got found=%0b idx=%0d start=%h end=%h err=%0b",
                     found, match_index, data_start, data_end, order_error);
        end
      end
    end
  end

  // tests

  task automatic test_directed();
    send_load(0, 32'h8000_0000, 32'h0, 32'h0);
    send_load(1, 32'h8000_0000, $urandom, $urandom);
    send_load(1, 32'h7fff_ffff, $urandom, $urandom);
    send_load(2, 32'h0000_0000, $urandom, $urandom);
    pick_count = 0;
    insert_pick(pack_text("README12.TXT"), 1'b0);
    insert_pick(pack_text("B"), 1'b0);
    insert_pick(96'h0000_0000_0000_00c1_7a80_ffe9, 1'b0);
    insert_pick('0, 1'b0);
    load_picks(1'b0);
    send_load(0, pick_key[0], 32'hffff_ffff, 32'hffff_ffff);
    configure(1'b0, 4);
    for (int i = 0; i < 4; i++) send_lookup(pick_name[i]);
    send_lookup(pack_text("readme12.txt"));
    send_lookup(pack_text("B") | (96'h41 << 16));
    send_lookup(pack_text("NOSUCH.NAME"));
    configure(1'b0, 0);
    send_lookup(pack_text("B"));
    pick_count = 0;
    insert_pick(pack_text("00_0000"), 1'b1);
    insert_pick(pack_text("12_3456"), 1'b1);
    insert_pick(pack_text("99_9999"), 1'b1);
    load_picks(1'b0);
    configure(1'b1, 3);
    send_lookup(pack_text("12x3456"));
    send_lookup(pack_text("99_9999"));
    send_lookup(pack_text("AB"));
  endtask

  task automatic test_random_tables(input int rounds);
    bit talk;
    int n;
    for (int k = 0; k < rounds; k++) begin
      talk = ($urandom_range(0, 2) == 0);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 96) : $urandom_range(1, 24);
      sender_steady   = ($urandom_range(0, 4) == 0);
      receiver_steady = ($urandom_range(0, 4) == 0);
      build_table(talk, n);
      load_picks(1'b1);
      configure(talk, ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n);
      send_lookup_mix($urandom_range(15, 35));
    end
  endtask

  task automatic test_full_directory();
    build_table(1'b0, DIR_DEPTH);
    receiver_steady = 1'b0;
    sender_steady   = 1'b1;
    hold_off_req    = 1'b1;
    load_picks(1'b1);
    sender_steady = 1'b0;
    configure(1'b0, DIR_DEPTH);
    send_lookup_mix(120);
    configure(1'b0, 11'h7ff);
    send_lookup_mix(50);
    configure(1'b0, $urandom_range(DIR_DEPTH + 1, 2046));
    send_lookup_mix(30);
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = REG_TALK_MODE;
    cfg_data        = '0;
    req_valid       = 1'b0;
    action          = ACT_LOAD;
    load_index      = '0;
    load_hash       = '0;
    load_offset     = '0;
    load_length     = '0;
    name_chars_0_3  = '0;
    name_chars_4_7  = '0;
    name_chars_8_11 = '0;
    talk_sel        = 1'b0;
    entry_total     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_tables(13);
    test_full_directory();

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("covered %0d entry loads (%0d out of order) and %0d lookups (%0d hits)",
             loads_sent, order_errors_due, lookups_sent, hits_due);
    $display("both id modes, entry counts up to %0d, %0d long response hold-off(s)",
             widest_count, hold_offs);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d words still awaited", mismatches,
               awaited_replies.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/adl_pkg.sv
hdl/adl_dir_ram.sv
hdl/adl_key_unit.sv
hdl/archive_directory_lookup.sv
tb/sv/archive_directory_lookup_tb.sv
